// ===== rtl/pcpa_pkg.sv =====
// Shared types and codes for the per-CPU page allocator.
package pcpa_pkg;

   localparam int ADDR_W   = 32;
   localparam int CPU_W    = 3;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 32;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_PAGE  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = 2'd2;

   localparam logic CSR_POOL_LOW = 1'b0;
   localparam logic CSR_POOL_TOP = 1'b1;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_LREAD = 7'b0000010,
      ST_POP   = 7'b0000100,
      ST_SCAN  = 7'b0001000,
      ST_WALK  = 7'b0010000,
      ST_VWR   = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

endpackage

// ===== rtl/pcpa_if.sv =====
// Request and response channel interfaces of the page allocator.
interface pcpa_req_if;
   logic                        valid;
   logic                        ready;
   logic                        mode;
   logic [pcpa_pkg::CPU_W-1:0]  cpu;
   logic [pcpa_pkg::ADDR_W-1:0] page_address;

   modport source (output valid, mode, cpu, page_address, input ready);
   modport sink   (input valid, mode, cpu, page_address, output ready);
endinterface

interface pcpa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pcpa_pkg::ADDR_W-1:0]   granted_address;
   logic [pcpa_pkg::STATUS_W-1:0] status;
   logic                          stole;

   modport source (output valid, granted_address, status, stole, input ready);
   modport sink   (input valid, granted_address, status, stole, output ready);
endinterface

// ===== rtl/pcpa_link_ram.sv =====
// Page-indexed next-link memory, one write and one registered read port.
module pcpa_link_ram #(
   parameter int DEPTH = 32768,
   parameter int WIDTH = 15
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ===== rtl/per_cpu_page_allocator_top.sv =====
// Per-CPU page allocator: sequencer, list table and free-address check.
// A free goes through LREAD and DONE to the response register, a local alloc
// through LREAD, POP and DONE. A steal scans one CPU entry per cycle, then
// walks floor(n/2)+1 links of the victim list one per cycle through the link
// memory read port. One request is in flight; the next is taken once done.
// Reset (synchronous) empties every list through per-CPU valid bits; the link
// memory needs no clearing.
module per_cpu_page_allocator_top #(
   parameter int NUM_CPUS   = 8,
   parameter int NUM_PAGES  = 32768,
   parameter int PAGE_BYTES = 4096
) (
   input  logic                        clock,
   input  logic                        reset,
   pcpa_req_if.sink                    req_bus,
   pcpa_rsp_if.source                  rsp_bus,
   input  logic                        csr_we,
   input  logic                        csr_index,
   input  logic [pcpa_pkg::ADDR_W-1:0] csr_wdata
);
   localparam int PW  = $clog2(NUM_PAGES);
   localparam int CW  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
   localparam int S   = $clog2(PAGE_BYTES);
   localparam int BPW = 33 - S;
   localparam int KW  = pcpa_pkg::COUNT_W;
   localparam int AW  = pcpa_pkg::ADDR_W;

   pcpa_pkg::state_type state_ff, state_in;

   logic [AW-1:0] pool_low_ff, pool_top_ff;
   logic          mode_ff;
   logic [CW-1:0] cpu_ff, cpu_idx;
   logic [AW-1:0] addr_ff;
   logic [PW-1:0] cur_head_ff, cur_head_in;
   logic [KW-1:0] cur_cnt_ff, cur_cnt_in;
   logic [CW-1:0] scan_v_ff, scan_v_in, vic_ff, vic_in;
   logic [PW-1:0] vhead_ff, vhead_in, first_ff, first_in;
   logic [KW-1:0] vcnt_ff, vcnt_in, take_ff, take_in, rcnt_ff, rcnt_in;
   logic [AW-1:0] res_addr_ff, res_addr_in;
   logic [pcpa_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic          res_stole_ff, res_stole_in;
   logic          rsp_valid_ff;
   logic [AW-1:0] rsp_addr_ff;
   logic [pcpa_pkg::STATUS_W-1:0] rsp_status_ff;
   logic          rsp_stole_ff;

   // list table: head and count per CPU, registered read, valid bits for reset
   logic [PW-1:0] head_mem [NUM_CPUS];
   logic [KW-1:0] cnt_mem  [NUM_CPUS];
   logic [NUM_CPUS-1:0] list_vld_ff;
   logic          list_re, list_we;
   logic [CW-1:0] list_raddr, list_waddr;
   logic [PW-1:0] list_whead;
   logic [KW-1:0] list_wcnt;
   logic [PW-1:0] lrd_head_ff;
   logic [KW-1:0] lrd_cnt_ff;
   logic          lrd_vld_ff;
   logic [PW-1:0] lhead;
   logic [KW-1:0] lcnt;

   logic          link_we, link_re;
   logic [PW-1:0] link_waddr, link_wdata, link_raddr, link_rdata;

   logic [BPW-1:0] base_page, idx_full;
   logic           free_bad;
   logic           out_free;

   pcpa_link_ram #(.DEPTH(NUM_PAGES), .WIDTH(PW)) u_link (
      .clock (clock),
      .we    (link_we),
      .waddr (link_waddr),
      .wdata (link_wdata),
      .re    (link_re),
      .raddr (link_raddr),
      .rdata (link_rdata)
   );

   function automatic logic [AW-1:0] page_addr(input logic [BPW-1:0] base,
                                               input logic [PW-1:0] idx);
      logic [BPW+PW:0] sum;
      sum = (BPW+PW+1)'(base) + (BPW+PW+1)'(idx);
      return {sum[AW-S-1:0], {S{1'b0}}};
   endfunction

   // fold the cpu field onto the configured CPU count
   always_comb begin
      cpu_idx = '0;
      for (int i = 0; i < 8; i++) begin
         if (req_bus.cpu == 3'(i)) cpu_idx = CW'(i % NUM_CPUS);
      end
   end

   assign base_page = {1'b0, pool_low_ff[AW-1:S]} + BPW'(|pool_low_ff[S-1:0]);
   assign idx_full  = {1'b0, addr_ff[AW-1:S]} - base_page;
   assign free_bad  = (addr_ff[S-1:0] != '0) || (addr_ff < pool_low_ff) ||
                      (addr_ff >= pool_top_ff) || (40'(idx_full) >= 40'(NUM_PAGES));

   assign lhead    = lrd_vld_ff ? lrd_head_ff : '0;
   assign lcnt     = lrd_vld_ff ? lrd_cnt_ff : '0;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   assign req_bus.ready           = (state_ff == pcpa_pkg::ST_IDLE);
   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.granted_address = rsp_addr_ff;
   assign rsp_bus.status          = rsp_status_ff;
   assign rsp_bus.stole           = rsp_stole_ff;

   always_comb begin
      state_in      = state_ff;
      cur_head_in   = cur_head_ff;
      cur_cnt_in    = cur_cnt_ff;
      scan_v_in     = scan_v_ff;
      vic_in        = vic_ff;
      vhead_in      = vhead_ff;
      first_in      = first_ff;
      vcnt_in       = vcnt_ff;
      take_in       = take_ff;
      rcnt_in       = rcnt_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      res_stole_in  = res_stole_ff;
      list_re       = 1'b0;
      list_raddr    = cpu_ff;
      list_we       = 1'b0;
      list_waddr    = cpu_ff;
      list_whead    = '0;
      list_wcnt     = '0;
      link_we       = 1'b0;
      link_waddr    = idx_full[PW-1:0];
      link_wdata    = lhead;
      link_re       = 1'b0;
      link_raddr    = lhead;
      unique case (state_ff)
         pcpa_pkg::ST_IDLE: begin
            if (req_bus.valid) begin
               list_re    = 1'b1;
               list_raddr = cpu_idx;
               state_in   = pcpa_pkg::ST_LREAD;
            end
         end
         pcpa_pkg::ST_LREAD: begin
            res_addr_in   = '0;
            res_status_in = pcpa_pkg::STATUS_OK;
            res_stole_in  = 1'b0;
            if (mode_ff == pcpa_pkg::MODE_FREE) begin
               if (free_bad) begin
                  res_status_in = pcpa_pkg::STATUS_BAD_FREE;
               end else begin
                  // push: link the page to the old head
                  link_we    = 1'b1;
                  list_we    = 1'b1;
                  list_whead = idx_full[PW-1:0];
                  list_wcnt  = lcnt + KW'(1);
               end
               state_in = pcpa_pkg::ST_DONE;
            end else if (lcnt != '0) begin
               cur_head_in = lhead;
               cur_cnt_in  = lcnt;
               link_re     = 1'b1;
               state_in    = pcpa_pkg::ST_POP;
            end else begin
               list_re    = 1'b1;
               list_raddr = '0;
               scan_v_in  = '0;
               state_in   = pcpa_pkg::ST_SCAN;
            end
         end
         pcpa_pkg::ST_POP: begin
            list_we     = 1'b1;
            list_whead  = link_rdata;
            list_wcnt   = cur_cnt_ff - KW'(1);
            res_addr_in = page_addr(base_page, cur_head_ff);
            state_in    = pcpa_pkg::ST_DONE;
         end
         pcpa_pkg::ST_SCAN: begin
            if (scan_v_ff != cpu_ff && lcnt != '0) begin
               vic_in   = scan_v_ff;
               vhead_in = lhead;
               take_in  = {1'b0, lcnt[KW-1:1]} + KW'(1);
               vcnt_in  = lcnt - ({1'b0, lcnt[KW-1:1]} + KW'(1));
               rcnt_in  = KW'(1);
               link_re  = 1'b1;
               state_in = pcpa_pkg::ST_WALK;
            end else if (scan_v_ff == CW'(NUM_CPUS - 1)) begin
               res_status_in = pcpa_pkg::STATUS_NO_PAGE;
               state_in      = pcpa_pkg::ST_DONE;
            end else begin
               scan_v_in  = scan_v_ff + CW'(1);
               list_re    = 1'b1;
               list_raddr = scan_v_ff + CW'(1);
            end
         end
         pcpa_pkg::ST_WALK: begin
            // link data of read number rcnt along the victim list
            if (rcnt_ff == KW'(1)) first_in = link_rdata;
            if (rcnt_ff == take_ff) begin
               list_we    = 1'b1;
               list_waddr = vic_ff;
               list_whead = link_rdata;
               list_wcnt  = vcnt_ff;
               state_in   = pcpa_pkg::ST_VWR;
            end else begin
               link_re    = 1'b1;
               link_raddr = link_rdata;
               rcnt_in    = rcnt_ff + KW'(1);
            end
         end
         pcpa_pkg::ST_VWR: begin
            list_we      = 1'b1;
            list_whead   = first_ff;
            list_wcnt    = take_ff - KW'(1);
            res_addr_in  = page_addr(base_page, vhead_ff);
            res_stole_in = 1'b1;
            state_in     = pcpa_pkg::ST_DONE;
         end
         pcpa_pkg::ST_DONE: begin
            if (out_free) state_in = pcpa_pkg::ST_IDLE;
         end
         default: state_in = pcpa_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (list_we) begin
         head_mem[list_waddr] <= list_whead;
         cnt_mem[list_waddr]  <= list_wcnt;
      end
      if (list_re) begin
         lrd_head_ff <= head_mem[list_raddr];
         lrd_cnt_ff  <= cnt_mem[list_raddr];
         lrd_vld_ff  <= list_vld_ff[list_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pcpa_pkg::ST_IDLE;
         list_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         pool_low_ff  <= '0;
         pool_top_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (list_we) list_vld_ff[list_waddr] <= 1'b1;
         if (csr_we && csr_index == pcpa_pkg::CSR_POOL_LOW) pool_low_ff <= csr_wdata;
         if (csr_we && csr_index == pcpa_pkg::CSR_POOL_TOP) pool_top_ff <= csr_wdata;
         if (state_ff == pcpa_pkg::ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == pcpa_pkg::ST_IDLE && req_bus.valid) begin
         mode_ff <= req_bus.mode;
         cpu_ff  <= cpu_idx;
         addr_ff <= req_bus.page_address;
      end
      if (state_ff == pcpa_pkg::ST_DONE && out_free) begin
         rsp_addr_ff   <= res_addr_ff;
         rsp_status_ff <= res_status_ff;
         rsp_stole_ff  <= res_stole_ff;
      end
      cur_head_ff   <= cur_head_in;
      cur_cnt_ff    <= cur_cnt_in;
      scan_v_ff     <= scan_v_in;
      vic_ff        <= vic_in;
      vhead_ff      <= vhead_in;
      first_ff      <= first_in;
      vcnt_ff       <= vcnt_in;
      take_ff       <= take_in;
      rcnt_ff       <= rcnt_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      res_stole_ff  <= res_stole_in;
   end

   a_pop_after_lread: assert property (@(posedge clock) disable iff (reset)
      state_ff == pcpa_pkg::ST_POP |-> $past(state_ff) == pcpa_pkg::ST_LREAD)
      else $error("pop entered without a list read");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == pcpa_pkg::ST_DONE)
      else $error("response raised outside completion");

   a_stole_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stole_ff |-> rsp_status_ff == pcpa_pkg::STATUS_OK)
      else $error("steal reported with error status");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == pcpa_pkg::ST_WALK |-> rcnt_ff <= take_ff && rcnt_ff != '0)
      else $error("link walk overran its length");

endmodule
